@@ src/pmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and constants shared by the pending message table.
// ----------------------------------------------------------------------------
`default_nettype none
package pmt_pkg;

  localparam int unsigned CNT_W = 6;
  localparam int unsigned MAX_REPORT = 16;
  localparam logic [31:0] TTL_RESET = 32'd60000;

  typedef enum logic [3:0] {
    OP_ADD         = 4'd0,
    OP_FIND_ID     = 4'd1,
    OP_FIND_CLIENT = 4'd2,
    OP_NODE_ACK    = 4'd3,
    OP_DELIVERED   = 4'd4,
    OP_FAILED      = 4'd5,
    OP_REMOVE_DLV  = 4'd6,
    OP_CLEANUP     = 4'd7,
    OP_COUNT       = 4'd8
  } op_e;

  // range of codes with no operation behind them
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_FORWARDED = 2'd1;
  localparam logic [1:0] ST_DELIVERED = 2'd2;
  localparam logic [1:0] ST_FAILED    = 2'd3;

  typedef struct packed {
    logic        used;
    logic [63:0] mid;
    logic [63:0] cid;
    logic [1:0]  st;
    logic        an;
    logic        ad;
    logic        al;
    logic [31:0] cr;
    logic [31:0] lt;
  } rec_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] mid;
    logic [63:0] cid;
    logic [31:0] now;
    logic [1:0]  st;
    logic        an;
    logic        ad;
    logic        al;
    logic [31:0] cr;
    logic [31:0] lt;
    logic [4:0]  lim;
  } ctx_t;

  typedef struct packed {
    logic match;
    logic emit;
    logic inc;
  } step_t;

endpackage
`default_nettype wire

@@ src/pmt_if.sv @@
// ----------------------------------------------------------------------------
// pmt request and result channels
// Valid/ready channels carrying table requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface pmt_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [63:0] message_id;
  logic [63:0] client_id;
  logic [31:0] now_ms;
  logic [1:0]  status_in;
  logic        await_node_in;
  logic        await_delivery_in;
  logic        await_local_in;
  logic [31:0] created_at_in;
  logic [31:0] last_try_in;
  logic [4:0]  report_limit;
  modport source (output valid, op, message_id, client_id, now_ms, status_in,
                  await_node_in, await_delivery_in, await_local_in, created_at_in,
                  last_try_in, report_limit, input ready);
  modport sink (input valid, op, message_id, client_id, now_ms, status_in,
                await_node_in, await_delivery_in, await_local_in, created_at_in,
                last_try_in, report_limit, output ready);
endinterface

interface pmt_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  slot;
  logic [63:0] id_out;
  logic [63:0] client_out;
  logic [1:0]  status_out;
  logic        await_node_out;
  logic        await_delivery_out;
  logic        await_local_out;
  logic [31:0] created_out;
  logic [31:0] last_try_out;
  logic [4:0]  tally;
  logic        last;
  modport source (output valid, hit, slot, id_out, client_out, status_out,
                  await_node_out, await_delivery_out, await_local_out, created_out,
                  last_try_out, tally, last, input ready);
  modport sink (input valid, hit, slot, id_out, client_out, status_out,
                await_node_out, await_delivery_out, await_local_out, created_out,
                last_try_out, tally, last, output ready);
endinterface
`default_nettype wire

@@ src/pmt_cell.sv @@
// ----------------------------------------------------------------------------
// pmt_cell
// One record of the ring; loads its neighbor's record on each shift.
// ----------------------------------------------------------------------------
`default_nettype none
module pmt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire pmt_pkg::rec_t rec_i,
  output pmt_pkg::rec_t      rec_o
);
  logic          used_q;
  pmt_pkg::rec_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= rec_i.used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= rec_i;
    end
  end

  always_comb begin
    rec_o      = data_q;
    rec_o.used = used_q;
  end
endmodule
`default_nettype wire

@@ src/pmt_step.sv @@
// ----------------------------------------------------------------------------
// pmt_step
// Applies the current request to the record leaving the head of the ring.
// ----------------------------------------------------------------------------
`default_nettype none
module pmt_step (
  input  wire pmt_pkg::rec_t               head_i,
  input  wire pmt_pkg::ctx_t               ctx_i,
  input  wire logic [31:0]                 ttl_i,
  input  wire logic                        found_i,
  input  wire logic [pmt_pkg::CNT_W-1:0]   n_i,
  output pmt_pkg::rec_t                    rec_o,
  output pmt_pkg::step_t                   ctl_o
);
  logic [31:0] age;
  logic        key_eq;

  assign age = ctx_i.now - head_i.cr;

  always_comb begin
    rec_o  = head_i;
    ctl_o  = '0;
    key_eq = (ctx_i.op == pmt_pkg::OP_FIND_CLIENT) ? (head_i.cid == ctx_i.cid)
                                                   : (head_i.mid == ctx_i.mid);
    case (ctx_i.op) inside
      pmt_pkg::OP_ADD: begin
        if (!found_i && !head_i.used) begin
          rec_o.used  = 1'b1;
          rec_o.mid   = ctx_i.mid;
          rec_o.cid   = ctx_i.cid;
          rec_o.st    = ctx_i.st;
          rec_o.an    = ctx_i.an;
          rec_o.ad    = ctx_i.ad;
          rec_o.al    = ctx_i.al;
          rec_o.cr    = ctx_i.cr;
          rec_o.lt    = ctx_i.lt;
          ctl_o.match = 1'b1;
        end
      end
      pmt_pkg::OP_FIND_ID, pmt_pkg::OP_FIND_CLIENT, pmt_pkg::OP_NODE_ACK,
      pmt_pkg::OP_DELIVERED, pmt_pkg::OP_FAILED: begin
        if (!found_i && head_i.used && key_eq) begin
          ctl_o.match = 1'b1;
          if (ctx_i.op == pmt_pkg::OP_NODE_ACK) begin
            rec_o.an = 1'b0;
            rec_o.lt = ctx_i.now;
            if (head_i.st == pmt_pkg::ST_PENDING) begin
              rec_o.st = pmt_pkg::ST_FORWARDED;
            end
          end else if (ctx_i.op == pmt_pkg::OP_DELIVERED ||
                       ctx_i.op == pmt_pkg::OP_FAILED) begin
            rec_o.an = 1'b0;
            rec_o.ad = 1'b0;
            rec_o.al = 1'b0;
            rec_o.st = (ctx_i.op == pmt_pkg::OP_DELIVERED) ? pmt_pkg::ST_DELIVERED
                                                           : pmt_pkg::ST_FAILED;
          end
        end
      end
      pmt_pkg::OP_REMOVE_DLV: begin
        if (head_i.used && head_i.st == pmt_pkg::ST_DELIVERED) begin
          rec_o.used = 1'b0;
          ctl_o.inc  = 1'b1;
        end
      end
      pmt_pkg::OP_CLEANUP: begin
        if (head_i.used && age > ttl_i) begin
          rec_o.used = 1'b0;
          if (n_i < pmt_pkg::CNT_W'(ctx_i.lim)) begin
            ctl_o.emit = 1'b1;
            ctl_o.inc  = 1'b1;
          end
        end
      end
      pmt_pkg::OP_COUNT: begin
        ctl_o.inc = head_i.used;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ src/pending_message_table.sv @@
// ----------------------------------------------------------------------------
// pending_message_table
// Table of outstanding messages held in a ring of record cells.
//
//   channel  dir  handshake     carries
//   in_i     in   valid/ready   one request (op and operands)
//   out_o    out  valid/ready   result records, final one has last set
//   cfg      in   cfg_we_i      ttl_ms
//
// After acceptance the ring rotates once through the step unit, one slot per
// cycle in ascending order while the result register is not stalled, then the
// final result is loaded into the output register. A stalled result register
// pauses the ring. In the ring, reset clears only the used bits. A new request
// is taken once the final result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module pending_message_table #(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned ID_BYTES    = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  pmt_in_if.sink           in_i,
  pmt_out_if.source        out_o
);
  localparam int unsigned CW = pmt_pkg::CNT_W;
  localparam logic [63:0] ID_MASK = (ID_BYTES >= 8) ? '1
                                    : ((64'd1 << (8 * ID_BYTES)) - 64'd1);

  pmt_pkg::rec_t  ring [TABLE_SLOTS];
  pmt_pkg::rec_t  step_rec;
  pmt_pkg::step_t step_ctl;
  pmt_pkg::ctx_t  ctx_q;
  pmt_pkg::rec_t  res_q;
  pmt_pkg::rec_t  emit_rec;
  logic [31:0]    ttl_q;
  logic           busy_q, found_q, ov_q;
  logic [CW-1:0]  cnt_q, n_q, res_slot_q;
  logic           advance, scan, shift, accept, ov_set;
  logic           rec_op, tally_op;
  logic [4:0]     tally;

  // output register
  logic          hit_q, last_q;
  logic [3:0]    slot_q;
  logic [4:0]    tally_q;
  pmt_pkg::rec_t out_rec_q;

  assign accept  = in_i.valid && in_i.ready;
  assign advance = busy_q && (!ov_q || out_o.ready);
  assign scan    = cnt_q < CW'(TABLE_SLOTS);
  assign shift   = advance && scan;
  assign ov_set  = (shift && step_ctl.emit) || (advance && !scan);
  assign tally   = (n_q > CW'(31)) ? 5'd31 : n_q[4:0];
  assign in_i.ready = !busy_q;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    pmt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  ((i == TABLE_SLOTS - 1) ? step_rec : ring[(i + 1) % TABLE_SLOTS]),
      .rec_o  (ring[i])
    );
  end

  pmt_step u_step (
    .head_i (ring[0]),
    .ctx_i  (ctx_q),
    .ttl_i  (ttl_q),
    .found_i(found_q),
    .n_i    (n_q),
    .rec_o  (step_rec),
    .ctl_o  (step_ctl)
  );

  always_comb begin
    emit_rec     = '0;
    emit_rec.mid = ring[0].mid;
  end

  always_comb begin
    rec_op   = 1'b0;
    tally_op = 1'b0;
    case (ctx_q.op) inside
      pmt_pkg::OP_ADD, pmt_pkg::OP_FIND_ID, pmt_pkg::OP_FIND_CLIENT,
      pmt_pkg::OP_NODE_ACK, pmt_pkg::OP_DELIVERED, pmt_pkg::OP_FAILED: rec_op = 1'b1;
      pmt_pkg::OP_REMOVE_DLV, pmt_pkg::OP_CLEANUP, pmt_pkg::OP_COUNT: tally_op = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= pmt_pkg::TTL_RESET;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      ov_q <= ov_set || (ov_q && !out_o.ready);
      if (accept) begin
        busy_q  <= 1'b1;
        found_q <= 1'b0;
        cnt_q   <= '0;
        n_q     <= '0;
      end else if (shift) begin
        cnt_q <= cnt_q + CW'(1);
        if (step_ctl.match) found_q <= 1'b1;
        if (step_ctl.inc) n_q <= n_q + CW'(1);
      end else if (advance) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctx_q.op  <= in_i.op;
      ctx_q.mid <= in_i.message_id & ID_MASK;
      ctx_q.cid <= in_i.client_id & ID_MASK;
      ctx_q.now <= in_i.now_ms;
      ctx_q.st  <= in_i.status_in;
      ctx_q.an  <= in_i.await_node_in;
      ctx_q.ad  <= in_i.await_delivery_in;
      ctx_q.al  <= in_i.await_local_in;
      ctx_q.cr  <= in_i.created_at_in;
      ctx_q.lt  <= in_i.last_try_in;
      ctx_q.lim <= (in_i.report_limit > 5'(pmt_pkg::MAX_REPORT))
                   ? 5'(pmt_pkg::MAX_REPORT) : in_i.report_limit;
    end
    if (shift && step_ctl.match) begin
      res_q      <= step_rec;
      res_slot_q <= cnt_q;
    end
    if (shift && step_ctl.emit) begin
      hit_q     <= 1'b1;
      slot_q    <= 4'(cnt_q);
      out_rec_q <= emit_rec;
      tally_q   <= '0;
      last_q    <= 1'b0;
    end else if (advance && !scan) begin
      last_q <= 1'b1;
      if (rec_op && found_q) begin
        hit_q     <= 1'b1;
        slot_q    <= 4'(res_slot_q);
        out_rec_q <= res_q;
        tally_q   <= '0;
      end else begin
        hit_q     <= 1'b0;
        slot_q    <= '0;
        out_rec_q <= '0;
        tally_q   <= tally_op ? tally : 5'd0;
      end
    end
  end

  assign out_o.valid              = ov_q;
  assign out_o.hit                = hit_q;
  assign out_o.slot               = slot_q;
  assign out_o.id_out             = out_rec_q.mid;
  assign out_o.client_out         = out_rec_q.cid;
  assign out_o.status_out         = out_rec_q.st;
  assign out_o.await_node_out     = out_rec_q.an;
  assign out_o.await_delivery_out = out_rec_q.ad;
  assign out_o.await_local_out    = out_rec_q.al;
  assign out_o.created_out        = out_rec_q.cr;
  assign out_o.last_try_out       = out_rec_q.lt;
  assign out_o.tally              = tally_q;
  assign out_o.last               = last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_SLOTS)) else $error("scan counter out of range");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && cnt_q == '0) else $error("request not started");
  a_final_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !scan) |=> !busy_q && ov_q && last_q) else $error("final result lost");
  a_emit_cleanup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift && step_ctl.emit) |-> ctx_q.op == pmt_pkg::OP_CLEANUP)
    else $error("id emitted outside cleanup");
endmodule
`default_nettype wire
